// ===== rtl/idf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the integer divider with flags.
// Used by idf_div_step and integer_divider_with_flags; depends on nothing.
package idf_pkg;

    localparam int DVD_W  = 64;
    localparam int DVS_W  = 32;
    localparam int RES_W  = 32;
    localparam int NSTEPS = 32;

    // Request codes.
    localparam logic [1:0] OP_DIVU_W = 2'd0;
    localparam logic [1:0] OP_DIVS_W = 2'd1;
    localparam logic [1:0] OP_DIVU_L = 2'd2;
    localparam logic [1:0] OP_DIVS_L = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DVZ = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    // Flag bits.
    localparam int FLAG_N = 3;
    localparam int FLAG_Z = 2;
    localparam int FLAG_V = 1;
    localparam int FLAG_C = 0;

    localparam logic [RES_W-1:0] LIM_UW = 32'h0000_FFFF;
    localparam logic [RES_W-1:0] LIM_SW = 32'h0000_7FFF;
    localparam logic [RES_W-1:0] LIM_SL = 32'h7FFF_FFFF;

    // Word in flight through the divide pipeline.
    typedef struct packed {
        logic [DVS_W-1:0] rem;   // partial remainder
        logic [RES_W-1:0] lo;    // low dividend bits, quotient shifts in at bottom
        logic [DVS_W-1:0] dvs;   // divisor magnitude
        logic             word;
        logic             sgn;
        logic             na;    // dividend negative
        logic             nq;    // quotient negative
        logic             dvz;
        logic             ovf;   // quotient known too wide for 32 bits
    } t_work;

endpackage

// ===== rtl/idf_div_step.sv =====
`timescale 1ns / 1ps
// One restoring division step: shifts in one dividend bit, yields one quotient bit.
// Depends on idf_pkg.
module idf_div_step (
    input  idf_pkg::t_work i_w,
    output idf_pkg::t_work o_w
);
    import idf_pkg::*;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           take;

    always_comb begin
        trial = {i_w.rem, i_w.lo[RES_W-1]};
        diff  = trial - {1'b0, i_w.dvs};
        take  = (trial >= {1'b0, i_w.dvs});
        o_w     = i_w;
        o_w.rem = take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        o_w.lo  = {i_w.lo[RES_W-2:0], take};
    end

endmodule

// ===== rtl/integer_divider_with_flags.sv =====
`timescale 1ns / 1ps
// Top level of the pipelined integer divider with N/Z/V/C flags and status.
// Depends on idf_pkg and idf_div_step.

// The block divides a 64-bit (or 32-bit word-form) dividend by a 32-bit (or 16-bit)
// divisor, signed or unsigned, and returns quotient, remainder, flags and status.
// It is a 34-stage pipeline: one stage takes magnitudes, 32 stages each produce
// one quotient bit in a restoring subtract, and a final stage restores signs,
// checks range and forms the flags. A new word is accepted every cycle while the
// pipeline has room. A request passes the magnitude stage, the 32 step stages
// and the final stage in turn before o_out_valid rises with its result.
// Each stage has its own valid bit and its own ready, so bubbles are squeezed
// out when the output stalls and input keeps flowing until the pipe is full.
module integer_divider_with_flags (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_req_type,
    input  logic [idf_pkg::DVD_W-1:0]   i_dividend,
    input  logic [idf_pkg::DVS_W-1:0]   i_divisor,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [idf_pkg::RES_W-1:0]   o_quotient,
    output logic [idf_pkg::RES_W-1:0]   o_remainder,
    output logic [3:0]                  o_cond_flags,
    output logic [1:0]                  o_status
);
    import idf_pkg::*;

    // Stage 0 holds magnitudes; stages 1..NSTEPS hold division steps.
    t_work             r_w [0:NSTEPS];
    logic [NSTEPS+1:0] r_v;          // bit NSTEPS+1 is the output register
    logic [NSTEPS+1:0] rdy;
    t_work             step_in [0:NSTEPS-1];
    t_work             step_out [0:NSTEPS-1];

    // Input decode and magnitudes.
    logic              in_word;
    logic              in_sgn;
    logic [DVD_W-1:0]  a64;
    logic [DVS_W-1:0]  b32;
    logic              in_na;
    logic              in_nb;
    logic [DVD_W-1:0]  ma;
    logic [DVS_W-1:0]  mb;
    t_work             n_w0;

    always_comb begin
        in_word = (i_req_type == OP_DIVU_W) || (i_req_type == OP_DIVS_W);
        in_sgn  = (i_req_type == OP_DIVS_W) || (i_req_type == OP_DIVS_L);
        if (in_word) begin
            a64 = {{32{in_sgn & i_dividend[31]}}, i_dividend[31:0]};
            b32 = {{16{in_sgn & i_divisor[15]}}, i_divisor[15:0]};
        end else begin
            a64 = i_dividend;
            b32 = i_divisor;
        end
        in_na = in_sgn & a64[DVD_W-1];
        in_nb = in_sgn & b32[DVS_W-1];
        ma    = in_na ? (~a64 + 64'd1) : a64;
        mb    = in_nb ? (~b32 + 32'd1) : b32;
        n_w0.rem  = ma[DVD_W-1:RES_W];
        n_w0.lo   = ma[RES_W-1:0];
        n_w0.dvs  = mb;
        n_w0.word = in_word;
        n_w0.sgn  = in_sgn;
        n_w0.na   = in_na;
        n_w0.nq   = in_na ^ in_nb;
        n_w0.dvz  = (b32 == '0);
        n_w0.ovf  = 1'b0;
    end

    // Ready ripples back from the output register through each stage.
    always_comb begin
        rdy[NSTEPS+1] = !r_v[NSTEPS+1] || i_out_ready;
        for (int k = NSTEPS; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end
    assign o_in_ready = rdy[0];

    // The first step also flags a quotient wider than 32 bits: the upper
    // dividend half must stay below the divisor.
    always_comb begin
        step_in[0]     = r_w[0];
        step_in[0].ovf = r_w[0].ovf | (r_w[0].rem >= r_w[0].dvs);
        for (int k = 1; k < NSTEPS; k++) begin
            step_in[k] = r_w[k];
        end
    end

    for (genvar g = 0; g < NSTEPS; g++) begin : g_step
        idf_div_step u_step (
            .i_w (step_in[g]),
            .o_w (step_out[g])
        );
    end

    // Final stage: signs, range check, flags.
    t_work            wf;
    logic [RES_W-1:0] qm;
    logic [RES_W-1:0] rm;
    logic [RES_W-1:0] lim;
    logic             f_ovf;
    logic [RES_W-1:0] q_s;
    logic [RES_W-1:0] r_s;
    logic [RES_W-1:0] q_m;
    logic [RES_W-1:0] r_m;
    logic [RES_W-1:0] n_q;
    logic [RES_W-1:0] n_r;
    logic [3:0]       n_f;
    logic [1:0]       n_st;

    always_comb begin
        wf  = r_w[NSTEPS];
        qm  = wf.lo;
        rm  = wf.rem;
        lim = !wf.sgn ? (wf.word ? LIM_UW : {RES_W{1'b1}})
                      : (wf.word ? LIM_SW : LIM_SL);
        if (wf.nq && wf.sgn) begin
            f_ovf = wf.ovf || (qm > lim + 32'd1);
        end else begin
            f_ovf = wf.ovf || (qm > lim);
        end
        q_s = (wf.sgn && wf.nq) ? (~qm + 32'd1) : qm;
        r_s = (wf.sgn && wf.na) ? (~rm + 32'd1) : rm;
        q_m = wf.word ? {16'd0, q_s[15:0]} : q_s;
        r_m = wf.word ? {16'd0, r_s[15:0]} : r_s;
        n_q  = '0;
        n_r  = '0;
        n_f  = '0;
        n_st = ST_OK;
        if (wf.dvz) begin
            n_st = ST_DVZ;
        end else if (f_ovf) begin
            n_st = ST_OVF;
            n_f[FLAG_V] = 1'b1;
        end else begin
            n_q = q_m;
            n_r = r_m;
            n_f[FLAG_Z] = (q_m == '0);
            n_f[FLAG_N] = wf.word ? q_m[15] : q_m[31];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 0; k <= NSTEPS; k++) begin
                if (rdy[k+1]) begin
                    r_v[k+1] <= r_v[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_in_valid) begin
            r_w[0] <= n_w0;
        end
        for (int k = 0; k < NSTEPS; k++) begin
            if (rdy[k+1] && r_v[k]) begin
                r_w[k+1] <= step_out[k];
            end
        end
        if (rdy[NSTEPS+1] && r_v[NSTEPS]) begin
            o_quotient   <= n_q;
            o_remainder  <= n_r;
            o_cond_flags <= n_f;
            o_status     <= n_st;
        end
    end

    assign o_out_valid = r_v[NSTEPS+1];

`ifndef SYNTHESIS
    a_dvz_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_DVZ) |-> (o_quotient == '0 && o_cond_flags == '0))
        else $error("divide by zero result not cleared");
    a_ovf_flags : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_OVF) |-> (o_cond_flags == 4'b0010 && o_remainder == '0))
        else $error("overflow result has wrong flags");
    a_c_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_cond_flags[FLAG_C])
        else $error("carry flag set");
    a_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_v[0] && r_v[NSTEPS+1]))
        else $error("input stalled with room in pipeline");
    a_rst_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
`endif

endmodule
